FILE: design/frti_pkg.sv
`timescale 1ns / 1ps
package frti_pkg;

  typedef enum logic [1:0] {
    CMD_FLOOR = 2'd0,
    CMD_CEIL  = 2'd1,
    CMD_ROUND = 2'd2,
    CMD_INT32 = 2'd3
  } cmd_t;

  localparam logic [7:0]  EXP_MAX   = 8'hFF;
  localparam logic [7:0]  EXP_BIAS  = 8'd127;
  localparam logic [7:0]  EXP_INTEG = 8'd150;
  localparam logic [7:0]  EXP_INT32 = 8'd158;
  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
  localparam logic [31:0] MIN_I32_F = 32'hCF00_0000;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] MAX_I32   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] float_result;
    logic [31:0] int_result;
    logic        saturated;
    logic        nan_input;
  } result_t;

endpackage

FILE: design/float_round_to_integral.sv
`timescale 1ns / 1ps
// Channel | Ports                                          | Direction
// in      | in_valid, in_stall, in_command, in_operand_bits | receive
// out     | out_valid, out_stall, out_float_result,          | send
//         |   out_int_result, out_saturated, out_nan_input   |
// One transaction per cycle while out_stall is low.
// Input register feeds one combinational rounding pass into a result register.
// Reset (rst_n low, synchronous) empties both register stages.
// A stall on out holds the result; in stalls only when both stages are full.
module float_round_to_integral (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [31:0]         in_operand_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_float_result,
  output logic signed [31:0]  out_int_result,
  output logic                out_saturated,
  output logic                out_nan_input
);
  import frti_pkg::*;

  logic        in_v_r, in_v_nxt;
  cmd_t        cmd_r;
  logic [31:0] op_r;
  logic        out_v_r, out_v_nxt;
  result_t     res_r;
  result_t     res_c;
  logic        adv;

  frti_core u_core (.cmd(cmd_r), .u(op_r), .res(res_c));

  // advance the input stage when the result stage is free
  assign adv      = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !adv;

  always_comb begin
    in_v_nxt  = in_v_r;
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = in_v_r;
      in_v_nxt  = 1'b0;
    end
    if (in_valid && !in_stall) begin
      in_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // load payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r <= cmd_t'(in_command);
      op_r  <= in_operand_bits;
    end
    if (adv && in_v_r) begin
      res_r <= res_c;
    end
  end

  assign out_valid        = out_v_r;
  assign out_float_result = res_r.float_result;
  assign out_int_result   = res_r.int_result;
  assign out_saturated    = res_r.saturated;
  assign out_nan_input    = res_r.nan_input;

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(res_r))
    else $error("result changed under stall");

  // saturation only in integer mode
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_float_result == 32'd0)
    else $error("saturation outside integer mode");

  // accepted transaction reaches the input stage
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_v_r)
    else $error("accepted transaction lost");

endmodule

FILE: design/frti_core.sv
`timescale 1ns / 1ps
module frti_core (
  input  frti_pkg::cmd_t    cmd,
  input  logic [31:0]       u,
  output frti_pkg::result_t res
);
  import frti_pkg::*;

  logic        s;
  logic [7:0]  e;
  logic [30:0] mag;
  logic [23:0] full;
  logic [4:0]  shift;
  logic [31:0] fmask;
  logic [31:0] half;
  logic [31:0] frac;
  logic [31:0] trunc;
  logic        up;
  logic [31:0] fres;
  logic [31:0] imag;
  logic [31:0] ires;
  logic        sat;
  logic [2:0]  lsh;

  assign s     = u[31];
  assign e     = u[30:23];
  assign mag   = u[30:0];
  assign full  = {1'b1, u[22:0]};
  assign shift = 5'(EXP_INTEG - e);
  assign fmask = (32'd1 << shift) - 32'd1;
  assign half  = 32'd1 << (shift - 5'd1);
  assign frac  = u & fmask;
  assign trunc = u & ~fmask;
  assign lsh   = 3'(e - EXP_INTEG);

  // float modes
  always_comb begin
    up   = 1'b0;
    fres = u;
    if (e == EXP_MAX || e >= EXP_INTEG) begin
      fres = u;
    end else if (e < EXP_BIAS) begin
      case (cmd)
        CMD_FLOOR: fres = (s && mag != 31'd0) ? (SIGN_BIT | ONE_BITS) : {s, 31'd0};
        CMD_CEIL:  fres = (!s && mag != 31'd0) ? ONE_BITS : {s, 31'd0};
        default:   fres = (e == EXP_BIAS - 8'd1) ? ({s, 31'd0} | ONE_BITS) : {s, 31'd0};
      endcase
    end else if (frac != 32'd0) begin
      case (cmd)
        CMD_FLOOR: up = s;
        CMD_CEIL:  up = !s;
        default:   up = (frac >= half);
      endcase
      fres = up ? trunc + (32'd1 << shift) : trunc;
    end
  end

  // integer mode
  always_comb begin
    sat  = 1'b0;
    imag = 32'd0;
    ires = 32'd0;
    if (e == EXP_MAX && u[22:0] != 23'd0) begin
      ires = 32'd0;
    end else if (e >= EXP_INT32) begin
      if (u == MIN_I32_F) begin
        ires = SIGN_BIT;
      end else begin
        ires = s ? SIGN_BIT : MAX_I32;
        sat  = 1'b1;
      end
    end else begin
      if (e < EXP_BIAS - 8'd1) begin
        imag = 32'd0;
      end else if (e == EXP_BIAS - 8'd1) begin
        imag = 32'd1;
      end else if (e < EXP_INTEG) begin
        imag = ({8'd0, full} >> shift) +
               32'((({8'd0, full} & fmask) >= half) ? 1 : 0);
      end else begin
        imag = {8'd0, full} << lsh;
      end
      ires = s ? (32'd0 - imag) : imag;
    end
  end

  assign res.nan_input    = (e == EXP_MAX) && (u[22:0] != 23'd0);
  assign res.float_result = (cmd == CMD_INT32) ? 32'd0 : fres;
  assign res.int_result   = (cmd == CMD_INT32) ? ires : 32'd0;
  assign res.saturated    = (cmd == CMD_INT32) ? sat : 1'b0;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import frti_pkg::*;

  localparam int NUM_RANDOM = 1200;
  localparam int IDLE_LIMIT = 2000;

  // Predict the rounding result of one transaction
  function automatic result_t predict_round(cmd_t cmd, logic [31:0] u);
    result_t r;
    logic        neg;
    logic [7:0]  ex;
    logic [30:0] mag;
    logic [31:0] fmask, frac, full, imag;
    int          sh;
    logic        up;
    neg = u[31];
    ex  = u[30:23];
    mag = u[30:0];
    r = '0;
    r.nan_input = (ex == EXP_MAX) && (u[22:0] != 0);
    if (cmd != CMD_INT32) begin
      if (ex == EXP_MAX || ex >= EXP_INTEG) begin
        r.float_result = u;
      end else if (ex < EXP_BIAS) begin
        if (cmd == CMD_FLOOR)
          r.float_result = (neg && mag != 0) ? (SIGN_BIT | ONE_BITS) : {neg, 31'd0};
        else if (cmd == CMD_CEIL)
          r.float_result = (!neg && mag != 0) ? ONE_BITS : {neg, 31'd0};
        else
          r.float_result = (ex == EXP_BIAS - 8'd1) ? ({neg, 31'd0} | ONE_BITS)
                                                 : {neg, 31'd0};
      end else begin
        sh = int'(EXP_INTEG) - int'(ex);
        fmask = (32'd1 << sh) - 32'd1;
        frac = u & fmask;
        if (frac == 0) begin
          r.float_result = u;
        end else begin
          if (cmd == CMD_FLOOR) up = neg;
          else if (cmd == CMD_CEIL) up = !neg;
          else up = frac >= (32'd1 << (sh - 1));
          r.float_result = up ? (u & ~fmask) + (32'd1 << sh) : (u & ~fmask);
        end
      end
    end else begin
      full = {9'd1, u[22:0]};
      if (r.nan_input) begin
        r.int_result = '0;
      end else if (ex >= EXP_INT32) begin
        if (u == MIN_I32_F) begin
          r.int_result = SIGN_BIT;
        end else begin
          r.int_result = neg ? SIGN_BIT : MAX_I32;
          r.saturated = 1'b1;
        end
      end else begin
        if (ex < EXP_BIAS - 8'd1) imag = 0;
        else if (ex == EXP_BIAS - 8'd1) imag = 1;
        else if (ex < EXP_INTEG) begin
          sh = int'(EXP_INTEG) - int'(ex);
          fmask = (32'd1 << sh) - 32'd1;
          imag = full >> sh;
          if ((full & fmask) >= (32'd1 << (sh - 1))) imag = imag + 1;
        end else begin
          imag = full << (int'(ex) - int'(EXP_INTEG));
        end
        r.int_result = neg ? (32'd0 - imag) : imag;
      end
    end
    return r;
  endfunction

  // Hold pending expectations and compare results in order
  class round_scoreboard;
    result_t pending[$];
    int      errors;

    function void note_input(cmd_t cmd, logic [31:0] u);
      pending.push_back(predict_round(cmd, u));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.float_result !== want.float_result) begin
        $error("float_result expected %h actual %h", want.float_result, got.float_result);
        errors++;
      end
      if (got.int_result !== want.int_result) begin
        $error("int_result expected %h actual %h", want.int_result, got.int_result);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated expected %b actual %b", want.saturated, got.saturated);
        errors++;
      end
      if (got.nan_input !== want.nan_input) begin
        $error("nan_input expected %b actual %b", want.nan_input, got.nan_input);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [31:0] in_operand_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_float_result;
  logic signed [31:0] out_int_result;
  logic        out_saturated;
  logic        out_nan_input;

  round_scoreboard sb = new();
  bit stim_done = 1'b0;
  int idle_cycles = 0;

  float_round_to_integral DUT (.*);

  initial forever #5 clk = ~clk;

  // Send one transaction after a random gap
  task automatic send_item(cmd_t cmd, logic [31:0] u);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_operand_bits <= u;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd, u);
  endtask

  // Build an operand near the interesting exponent range
  function automatic logic [31:0] pick_operand();
    logic [31:0] u;
    u = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: u[30:23] = 8'($urandom_range(120, 160));
      3: u[30:23] = 8'($urandom_range(125, 128));
      4: u[30:23] = $urandom_range(0, 1) ? EXP_MAX : 8'd0;
      5: u[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h400000 >> $urandom_range(0, 22);
      default: ;
    endcase
    return u;
  endfunction

  // Drive reset, directed cases, then random traffic
  initial begin
    logic [31:0] dir_ops[$];
    dir_ops = '{32'h0000_0000, 32'h8000_0000, 32'h3E99_999A, 32'hBE99_999A,
                32'h3F00_0000, 32'hBF00_0000, 32'h3EFF_FFFF, 32'h0000_0001,
                32'h8000_0001, 32'h3FC0_0000, 32'hC020_0000, 32'h4B7F_FFFF,
                32'h4B80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
                32'hFF80_0001, MIN_I32_F, 32'h4F00_0000, 32'hCF00_0001,
                32'h4EFF_FFFF, 32'hFFFF_FFFF, 32'h3F7F_FFFF};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_ops[i])
      send_item(cmd_t'(i % 4), dir_ops[i]);
    for (int c = 0; c < 4; c++) begin
      send_item(cmd_t'(c), 32'hBFC0_0000);
      send_item(cmd_t'(c), 32'h4A80_0001);
    end
    repeat (NUM_RANDOM) send_item(cmd_t'($urandom_range(0, 3)), pick_operand());
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Check results and stall the output at random
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result('{out_float_result, out_int_result, out_saturated, out_nan_input});
      if (out_valid && !out_stall || stall_left == 0) begin
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      end else begin
        stall_left = stall_left - 1;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Drain and report
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
